@@ sv/svpd_pkg.sv @@
package svpd_pkg;

    // Fixed-point constants
    localparam int unsigned DIV_STEPS = 17;
    localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;
    localparam logic [15:0] DUTY_HALF = 16'd16384;
    localparam logic [15:0] DUTY_ONE = 16'd32768;
    localparam logic [15:0] DUTY_MAX = 16'hFFFF;
    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    // Phase codes
    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    // Which phase takes the low, middle and top duty
    typedef struct packed {
        logic [1:0] lo;
        logic [1:0] mid;
        logic [1:0] top;
    } roles_t;

    // Active times after sector decode
    typedef struct packed {
        logic                valid;
        logic                en;
        roles_t              roles;
        logic signed [35:0]  t1;
        logic signed [35:0]  t2;
    } times_t;

    // Data that rides along the divider
    typedef struct packed {
        logic        valid;
        roles_t      roles;
        logic        overmod;
        logic        ratio_ok;
        logic [15:0] d_lo;
        logic [15:0] d_mid;
        logic [15:0] d_top;
    } side_t;

    // Round a Q31 time half up to Q15 and saturate
    function automatic logic [15:0] sat_duty(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'sd32768) >>> 16;
        if (v <= 36'sd0) begin
            return 16'd0;
        end
        if (r > 36'sd65535) begin
            return DUTY_MAX;
        end
        return r[15:0];
    endfunction

endpackage

@@ sv/svpd_sector.sv @@
module svpd_sector
    import svpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_fire,
    input  logic                enable,
    input  logic signed [15:0]  ref_alpha,
    input  logic signed [15:0]  ref_beta,
    output times_t              times
);

    logic               s1_valid_reg;
    logic               s1_en_reg;
    logic signed [31:0] s1_a_reg;
    logic signed [33:0] s1_b_reg;
    logic [30:0]        s1_ua2_reg;
    logic [30:0]        s1_ub2_reg;
    logic               s1_pa_reg;
    logic               s1_pb_reg;
    logic signed [33:0] b_next;
    logic signed [31:0] ua2_full;
    logic signed [31:0] ub2_full;
    times_t             times_reg;
    times_t             times_next;
    logic [32:0]        ua2_x3;
    logic               big_alpha;
    logic signed [35:0] ax;
    logic signed [35:0] bx;

    // Stage 1: products
    always_comb
    begin
        b_next   = 34'(ref_beta * $signed({1'b0, INV_SQRT3_Q16}));
        ua2_full = ref_alpha * ref_alpha;
        ub2_full = ref_beta * ref_beta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_en_reg  <= enable;
            s1_a_reg   <= {ref_alpha, 16'd0};
            s1_b_reg   <= b_next;
            s1_ua2_reg <= ua2_full[30:0];
            s1_ub2_reg <= ub2_full[30:0];
            s1_pa_reg  <= ~ref_alpha[15];
            s1_pb_reg  <= ~ref_beta[15];
        end
    end

    // Stage 2: sector and active times
    always_comb
    begin
        ua2_x3    = {1'b0, s1_ua2_reg, 1'b0} + {2'b0, s1_ua2_reg};
        big_alpha = ua2_x3 >= {2'b0, s1_ub2_reg};
        ax        = 36'(s1_a_reg);
        bx        = 36'(s1_b_reg);
        times_next       = '0;
        times_next.valid = s1_valid_reg;
        times_next.en    = s1_en_reg;
        if (big_alpha) begin
            if (s1_pa_reg) begin
                if (s1_pb_reg) begin
                    times_next.roles = '{lo: PH_U, mid: PH_V, top: PH_W};
                    times_next.t1    = ax - bx;
                    times_next.t2    = bx <<< 1;
                end else begin
                    times_next.roles = '{lo: PH_U, mid: PH_W, top: PH_V};
                    times_next.t1    = ax + bx;
                    times_next.t2    = -(bx <<< 1);
                end
            end else begin
                if (s1_pb_reg) begin
                    times_next.roles = '{lo: PH_V, mid: PH_W, top: PH_U};
                    times_next.t1    = bx <<< 1;
                    times_next.t2    = -bx - ax;
                end else begin
                    times_next.roles = '{lo: PH_W, mid: PH_V, top: PH_U};
                    times_next.t1    = -(bx <<< 1);
                    times_next.t2    = bx - ax;
                end
            end
        end else begin
            if (s1_pb_reg) begin
                times_next.roles = '{lo: PH_V, mid: PH_U, top: PH_W};
                times_next.t1    = bx - ax;
                times_next.t2    = ax + bx;
            end else begin
                times_next.roles = '{lo: PH_W, mid: PH_U, top: PH_V};
                times_next.t1    = -ax - bx;
                times_next.t2    = ax - bx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            times_reg <= '0;
        end else if (adv) begin
            times_reg <= times_next;
        end
    end

    assign times = times_reg;

endmodule

@@ sv/svpd_div_step.sv @@
module svpd_div_step
    import svpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [51:0] rem_in,
    input  logic [51:0] den_in,
    input  logic [16:0] quo_in,
    input  side_t       side_in,
    output logic [51:0] rem_out,
    output logic [51:0] den_out,
    output logic [16:0] quo_out,
    output side_t       side_out
);

    logic [51:0] rem_reg;
    logic [51:0] den_reg;
    logic [16:0] quo_reg;
    side_t       side_reg;
    logic        fits;

    // One restoring step: subtract when the shifted divisor fits
    assign fits = rem_in >= den_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_reg <= '0;
        end else if (adv) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            rem_reg <= fits ? (rem_in - den_in) : rem_in;
            den_reg <= den_in >> 1;
            quo_reg <= {quo_in[15:0], fits};
        end
    end

    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

@@ sv/space_vector_pwm_duty.sv @@
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------
// input    | in_valid / in_stall | enable, ref_alpha, ref_beta
// output   | out_valid/out_stall | duty_u, duty_v, duty_w
// config   | cfg_wr_en           | cfg_wr_data (overmod_extension)
// One request per cycle while in_stall is low; the stages are two sector stages, one time stage,
// 17 divider stages (one quotient bit each) and the output register.
// Reset clears the valid bits and the extension register.
// An output stall while out_valid is high freezes the whole pipeline; in_stall rises only then.
module space_vector_pwm_duty
    import svpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [13:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               enable,
    input  logic signed [15:0] ref_alpha,
    input  logic signed [15:0] ref_beta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        duty_u,
    output logic [15:0]        duty_v,
    output logic [15:0]        duty_w
);

    logic               adv;
    logic [13:0]        ext_reg;
    times_t             times;
    side_t              side_next;
    logic [51:0]        num_next;
    logic [51:0]        den_next;
    logic signed [35:0] s_sum;
    logic signed [35:0] t0;
    logic [15:0]        top_over;
    logic [51:0]        rem_c [DIV_STEPS+1];
    logic [51:0]        den_c [DIV_STEPS+1];
    logic [16:0]        quo_c [DIV_STEPS+1];
    side_t              side_c [DIV_STEPS+1];
    logic               out_valid_reg;
    logic [15:0]        duty_u_reg;
    logic [15:0]        duty_v_reg;
    logic [15:0]        duty_w_reg;
    logic [15:0]        d_mid_fin;
    logic [15:0]        u_next;
    logic [15:0]        v_next;
    logic [15:0]        w_next;
    side_t              fin;

    // Advance everything unless the output is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ext_reg <= '0;
        end else if (cfg_wr_en) begin
            ext_reg <= cfg_wr_data;
        end
    end

    svpd_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_fire   (in_valid),
        .enable    (enable),
        .ref_alpha (ref_alpha),
        .ref_beta  (ref_beta),
        .times     (times)
    );

    // Zero time, centered duties and the divider operands
    always_comb
    begin
        s_sum    = times.t1 + times.t2;
        t0       = ONE_Q30 - s_sum;
        top_over = DUTY_ONE + {1'b0, ext_reg, 1'b0};
        num_next = ({16'd0, times.t1} << 15) + {16'd0, s_sum >>> 1};
        den_next = {s_sum, 16'd0};
        side_next          = '0;
        side_next.valid    = times.valid;
        side_next.roles    = times.roles;
        side_next.ratio_ok = times.t1 > 36'sd0;
        if (!times.en) begin
            side_next.d_lo  = DUTY_HALF;
            side_next.d_mid = DUTY_HALF;
            side_next.d_top = DUTY_HALF;
        end else if (t0 > 36'sd0) begin
            side_next.d_lo  = sat_duty(t0);
            side_next.d_mid = sat_duty(ONE_Q30 + times.t1 - times.t2);
            side_next.d_top = sat_duty(ONE_Q30 + s_sum);
        end else begin
            side_next.overmod = 1'b1;
            side_next.d_lo    = 16'd0;
            side_next.d_top   = top_over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_c[0] <= '0;
        end else if (adv) begin
            side_c[0] <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            rem_c[0] <= num_next;
            den_c[0] <= den_next;
            quo_c[0] <= '0;
        end
    end

    // Divider chain, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        svpd_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .rem_in   (rem_c[k]),
            .den_in   (den_c[k]),
            .quo_in   (quo_c[k]),
            .side_in  (side_c[k]),
            .rem_out  (rem_c[k+1]),
            .den_out  (den_c[k+1]),
            .quo_out  (quo_c[k+1]),
            .side_out (side_c[k+1])
        );
    end

    // Pick the middle duty and route roles to phases
    always_comb
    begin
        fin = side_c[DIV_STEPS];
        if (!fin.overmod) begin
            d_mid_fin = fin.d_mid;
        end else if (!fin.ratio_ok) begin
            d_mid_fin = 16'd0;
        end else if (quo_c[DIV_STEPS][16]) begin
            d_mid_fin = DUTY_MAX;
        end else begin
            d_mid_fin = quo_c[DIV_STEPS][15:0];
        end
        u_next = (fin.roles.lo == PH_U) ? fin.d_lo :
                 (fin.roles.mid == PH_U) ? d_mid_fin : fin.d_top;
        v_next = (fin.roles.lo == PH_V) ? fin.d_lo :
                 (fin.roles.mid == PH_V) ? d_mid_fin : fin.d_top;
        w_next = (fin.roles.lo == PH_W) ? fin.d_lo :
                 (fin.roles.mid == PH_W) ? d_mid_fin : fin.d_top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            duty_u_reg <= u_next;
            duty_v_reg <= v_next;
            duty_w_reg <= w_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_u    = duty_u_reg;
    assign duty_v    = duty_v_reg;
    assign duty_w    = duty_w_reg;

endmodule
